>>> rtl/core/lti_pkg.sv
// ----------------------------------------------------------------------------
// lti_pkg
// shared types and constants of the line/triangle intersection engine
// ----------------------------------------------------------------------------
package lti_pkg;

    localparam int QUO_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int PARAM_W    = 32;
    localparam int WEIGHT_W   = 17;
    localparam int EPS_W      = 32;
    localparam int ADDR_W     = 5;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - PARAM_W - 2 * WEIGHT_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [PARAM_W-1:0] MISS_PARAM = 32'h7FFF_FFFF;
    localparam logic [PARAM_W-1:0] NEG_LIMIT  = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_DET_EPS  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic hit;
        logic neg;
        logic sat;
    } lti_flags_t;

endpackage

>>> rtl/core/lti_mul.sv
// ----------------------------------------------------------------------------
// lti_mul
// two-stage signed multiplier, second operand split into two halves
// ----------------------------------------------------------------------------
module lti_mul #(
    parameter int AW = 25,
    parameter int BW = 25
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LW = BW / 2;
    localparam int HW = BW - LW;

    logic signed [AW+LW:0]   lo_reg;
    logic signed [AW+HW-1:0] hi_reg;
    logic signed [AW+BW-1:0] p_reg;
    logic signed [AW+LW:0]   lo_next;
    logic signed [AW+HW-1:0] hi_next;
    logic signed [AW+BW-1:0] p_next;

    always_comb
    begin
        lo_next = (AW+LW+1)'(a) * (AW+LW+1)'($signed({1'b0, b[LW-1:0]}));
        hi_next = (AW+HW)'(a) * (AW+HW)'($signed(b[BW-1:LW]));
        p_next  = ((AW+BW)'(hi_reg) <<< LW) + (AW+BW)'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/core/lti_div.sv
// ----------------------------------------------------------------------------
// lti_div
// pipelined restoring divider, one quotient bit per stage, numerator scaled
// by 2^16
// ----------------------------------------------------------------------------
module lti_div #(
    parameter int DW = 79
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [DW-1:0]                num,
    input  logic [DW-1:0]                den,
    output logic [lti_pkg::QUO_W-1:0]    quo
);

    localparam int QW = lti_pkg::QUO_W;
    localparam int FW = lti_pkg::FRAC_W;

    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    logic [DW-1:0] rem_src [QW];
    logic [DW-1:0] den_src [QW];
    logic [QW-1:0] low_src [QW];
    logic [QW-1:0] q_src   [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] q_next   [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            logic [DW:0] trial;
            logic        ge;
            if (i == 0)
            begin : g_first
                assign rem_src[i] = num >> FW;
                assign den_src[i] = den;
                assign low_src[i] = {num[FW-1:0], (QW-FW)'(0)};
                assign q_src[i]   = '0;
            end
            else
            begin : g_rest
                assign rem_src[i] = rem_reg[i-1];
                assign den_src[i] = den_reg[i-1];
                assign low_src[i] = low_reg[i-1];
                assign q_src[i]   = q_reg[i-1];
            end
            always_comb
            begin
                trial       = {rem_src[i], low_src[i][QW-1]};
                ge          = trial >= {1'b0, den_src[i]};
                rem_next[i] = ge ? DW'(trial - {1'b0, den_src[i]}) : trial[DW-1:0];
                q_next[i]   = {q_src[i][QW-2:0], ge};
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next[i];
                    den_reg[i] <= den_src[i];
                    low_reg[i] <= {low_src[i][QW-2:0], 1'b0};
                    q_reg[i]   <= q_next[i];
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];

endmodule

>>> rtl/core/lti_fifo.sv
// ----------------------------------------------------------------------------
// lti_fifo
// short queue between the classify front end and the divide back end
// ----------------------------------------------------------------------------
module lti_fifo #(
    parameter int EW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [EW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic [EW-1:0] dout,
    output logic          empty
);

    localparam int DEPTH = lti_pkg::FIFO_DEPTH;

    logic [EW-1:0]                   mem_reg [DEPTH];
    logic [lti_pkg::FIFO_PTR_W-1:0]  wr_reg, wr_next;
    logic [lti_pkg::FIFO_PTR_W-1:0]  rd_reg, rd_next;
    logic [lti_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign full    = cnt_reg == lti_pkg::FIFO_CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

>>> rtl/core/lti_front.sv
// ----------------------------------------------------------------------------
// lti_front
// front end: edges, cross and dot products, sign fix-up and hit/miss
// classification and saturation check of each triangle
// ----------------------------------------------------------------------------
module lti_front #(
    parameter int W = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [W-1:0]         origin [3],
    input  logic signed [W-1:0]         dir [3],
    input  logic [lti_pkg::EPS_W-1:0]   eps,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [9*W-1:0]              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lti_pkg::lti_flags_t         out_flags,
    output logic [3*W+6:0]              out_det,
    output logic [3*W+6:0]              out_mag,
    output logic [3*W+6:0]              out_u,
    output logic [3*W+6:0]              out_v
);

    localparam int EW     = W + 1;
    localparam int CW     = 2 * W + 3;
    localparam int MW     = EW + CW;
    localparam int PW     = 3 * W + 7;
    localparam int STAGES = 10;
    localparam int FW     = lti_pkg::FRAC_W;

    logic                en;
    logic [STAGES-1:0]   v_reg;

    logic signed [EW-1:0] d_ext   [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] t0_next [3];
    logic signed [EW-1:0] e1_reg  [4][3];
    logic signed [EW-1:0] e2_reg  [4][3];
    logic signed [EW-1:0] t0_reg  [4][3];

    logic signed [2*EW-1:0] pa [3];
    logic signed [2*EW-1:0] pb [3];
    logic signed [2*EW-1:0] qa [3];
    logic signed [2*EW-1:0] qb [3];
    logic signed [CW-1:0]   p_reg [3];
    logic signed [CW-1:0]   q_reg [3];

    logic signed [MW-1:0] m_det [3];
    logic signed [MW-1:0] m_u   [3];
    logic signed [MW-1:0] m_v   [3];
    logic signed [MW-1:0] m_t   [3];

    logic signed [PW-1:0] det7_reg, u7_reg, v7_reg, t7_reg;
    logic signed [PW-1:0] det8_reg, u8_reg, v8_reg, t8_reg;
    logic signed [PW-1:0] det9_reg, u9_reg, v9_reg, mag9_reg;
    logic                 hit9_reg, neg9_reg;
    logic                 pos8;
    logic                 miss9_next;
    logic signed [PW-1:0] mag9_next;
    logic [PW-1:0]        det10_reg, mag10_reg, u10_reg, v10_reg;
    lti_pkg::lti_flags_t  flags10_reg;

    assign en        = !v_reg[STAGES-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_ext[k]   = EW'(dir[k]);
            e1_next[k] = EW'($signed(in_data[(3+k)*W +: W])) - EW'($signed(in_data[k*W +: W]));
            e2_next[k] = EW'($signed(in_data[(6+k)*W +: W])) - EW'($signed(in_data[k*W +: W]));
            t0_next[k] = EW'(origin[k]) - EW'($signed(in_data[k*W +: W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[0][k] <= e1_next[k];
                e2_reg[0][k] <= e2_next[k];
                t0_reg[0][k] <= t0_next[k];
                for (int s = 1; s < 4; s++)
                begin
                    e1_reg[s][k] <= e1_reg[s-1][k];
                    e2_reg[s][k] <= e2_reg[s-1][k];
                    t0_reg[s][k] <= t0_reg[s-1][k];
                end
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_axis
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;

            // p = dir x e2, q = (origin - a) x e1
            lti_mul #(.AW(EW), .BW(EW)) u_pa
                (.clk(clk), .en(en), .a(d_ext[K1]), .b(e2_reg[0][K2]), .p(pa[k]));
            lti_mul #(.AW(EW), .BW(EW)) u_pb
                (.clk(clk), .en(en), .a(d_ext[K2]), .b(e2_reg[0][K1]), .p(pb[k]));
            lti_mul #(.AW(EW), .BW(EW)) u_qa
                (.clk(clk), .en(en), .a(t0_reg[0][K1]), .b(e1_reg[0][K2]), .p(qa[k]));
            lti_mul #(.AW(EW), .BW(EW)) u_qb
                (.clk(clk), .en(en), .a(t0_reg[0][K2]), .b(e1_reg[0][K1]), .p(qb[k]));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[k] <= CW'(pa[k]) - CW'(pb[k]);
                    q_reg[k] <= CW'(qa[k]) - CW'(qb[k]);
                end
            end

            lti_mul #(.AW(EW), .BW(CW)) u_mdet
                (.clk(clk), .en(en), .a(e1_reg[3][k]), .b(p_reg[k]), .p(m_det[k]));
            lti_mul #(.AW(EW), .BW(CW)) u_mu
                (.clk(clk), .en(en), .a(t0_reg[3][k]), .b(p_reg[k]), .p(m_u[k]));
            lti_mul #(.AW(EW), .BW(CW)) u_mv
                (.clk(clk), .en(en), .a(d_ext[k]), .b(q_reg[k]), .p(m_v[k]));
            lti_mul #(.AW(EW), .BW(CW)) u_mt
                (.clk(clk), .en(en), .a(e2_reg[3][k]), .b(q_reg[k]), .p(m_t[k]));
        end
    endgenerate

    assign pos8 = det7_reg > 0;

    always_comb
    begin
        miss9_next = (det8_reg == 0)
                  || (det8_reg < $signed(PW'(eps)))
                  || (u8_reg < 0)
                  || (u8_reg > det8_reg)
                  || (v8_reg < 0)
                  || ((PW+1)'(u8_reg) + (PW+1)'(v8_reg) > (PW+1)'(det8_reg));
        mag9_next  = (t8_reg < 0) ? -t8_reg : t8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det7_reg <= PW'(m_det[0]) + PW'(m_det[1]) + PW'(m_det[2]);
            u7_reg   <= PW'(m_u[0]) + PW'(m_u[1]) + PW'(m_u[2]);
            v7_reg   <= PW'(m_v[0]) + PW'(m_v[1]) + PW'(m_v[2]);
            t7_reg   <= PW'(m_t[0]) + PW'(m_t[1]) + PW'(m_t[2]);

            // back face: flip determinant and every term built on origin - a
            det8_reg <= pos8 ? det7_reg : -det7_reg;
            u8_reg   <= pos8 ? u7_reg : -u7_reg;
            v8_reg   <= pos8 ? v7_reg : -v7_reg;
            t8_reg   <= pos8 ? t7_reg : -t7_reg;

            det9_reg <= det8_reg;
            u9_reg   <= u8_reg;
            v9_reg   <= v8_reg;
            mag9_reg <= mag9_next;
            neg9_reg <= t8_reg < 0;
            hit9_reg <= !miss9_next;

            flags10_reg.hit <= hit9_reg;
            flags10_reg.neg <= neg9_reg;
            flags10_reg.sat <= (mag9_reg >>> FW) >= det9_reg;
            det10_reg       <= det9_reg;
            mag10_reg       <= mag9_reg;
            u10_reg         <= u9_reg;
            v10_reg         <= v9_reg;
        end
    end

    assign out_flags = flags10_reg;
    assign out_det   = det10_reg;
    assign out_mag   = mag10_reg;
    assign out_u     = u10_reg;
    assign out_v     = v10_reg;

endmodule

>>> rtl/core/lti_back.sv
// ----------------------------------------------------------------------------
// lti_back
// back end: three pipelined dividers, saturation and the output register
// ----------------------------------------------------------------------------
module lti_back #(
    parameter int DW = 79
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lti_pkg::lti_flags_t               in_flags,
    input  logic [DW-1:0]                     in_det,
    input  logic [DW-1:0]                     in_mag,
    input  logic [DW-1:0]                     in_u,
    input  logic [DW-1:0]                     in_v,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lti_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam int QW = lti_pkg::QUO_W;
    localparam int PW = lti_pkg::PARAM_W;
    localparam int WW = lti_pkg::WEIGHT_W;

    logic                 en;
    logic [QW-1:0]        vld_reg;
    lti_pkg::lti_flags_t  flg_reg [QW];
    logic [QW-1:0]        qt, qu, qv;
    logic [PW-1:0]        lim, clip, param_next;
    logic [WW-1:0]        wu_next, wv_next;
    lti_pkg::lti_flags_t  fl;

    logic                 m_tvalid_reg;
    logic                 hit_reg;
    logic [PW-1:0]        param_reg;
    logic [WW-1:0]        wu_reg, wv_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign in_ready = en;

    lti_div #(.DW(DW)) u_div_t (.clk(clk), .en(en), .num(in_mag), .den(in_det), .quo(qt));
    lti_div #(.DW(DW)) u_div_u (.clk(clk), .en(en), .num(in_u),   .den(in_det), .quo(qu));
    lti_div #(.DW(DW)) u_div_v (.clk(clk), .en(en), .num(in_v),   .den(in_det), .quo(qv));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[QW-2:0], in_valid};
            m_tvalid_reg <= vld_reg[QW-1];
        end
    end

    always_comb
    begin
        fl   = flg_reg[QW-1];
        lim  = fl.neg ? lti_pkg::NEG_LIMIT : lti_pkg::MISS_PARAM;
        clip = (fl.sat || qt > lim) ? lim : qt;
        if (fl.hit)
        begin
            param_next = fl.neg ? PW'(0) - clip : clip;
            wu_next    = qu[WW-1:0];
            wv_next    = qv[WW-1:0];
        end
        else
        begin
            param_next = lti_pkg::MISS_PARAM;
            wu_next    = '0;
            wv_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[0] <= in_flags;
            for (int i = 1; i < QW; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
            hit_reg   <= fl.hit;
            param_reg <= param_next;
            wu_reg    <= wu_next;
            wv_reg    <= wv_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {lti_pkg::OUT_PAD_W'(0), wv_reg, wu_reg, param_reg};

endmodule

>>> rtl/core/line_triangle_intersect.sv
// ----------------------------------------------------------------------------
// line_triangle_intersect
// two-sided line/triangle crossing test against one configured line
// ----------------------------------------------------------------------------
// Takes one triangle per clock unless a stall holds s_tready low, and returns
// one result per triangle, in order. A result passes 10 front stages (split
// multipliers for the cross and dot products, then sign fix-up and
// classification), the 4-entry queue, 32 stages of the pipelined restoring
// dividers that form the parameter and both weights, and the output register.
// A stalled result holds the back end; the front end keeps accepting until the
// queue fills. Set the line and determinant threshold over APB while no
// triangle is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module line_triangle_intersect #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lti_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // triangle input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // corner_c_x, corner_c_y, corner_c_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // line_param, weight_u, weight_v, zero fill
    output logic [lti_pkg::OUT_DATA_W-1:0]    m_tdata,
    // hit
    output logic                              m_tuser
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 3 * W + 7;
    localparam int EW = 3 + 4 * PW;

    logic signed [W-1:0]             origin_reg [3];
    logic signed [W-1:0]             dir_reg    [3];
    logic [lti_pkg::EPS_W-1:0]       eps_reg;
    logic                            wr_en;
    lti_pkg::reg_index_t             idx;

    logic                            f_valid, q_full, q_empty, b_ready;
    lti_pkg::lti_flags_t             f_flags, b_flags;
    logic [PW-1:0]                   f_det, f_mag, f_u, f_v;
    logic [PW-1:0]                   b_det, b_mag, b_u, b_v;
    logic [EW-1:0]                   q_dout;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = lti_pkg::reg_index_t'(paddr[lti_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                origin_reg[k] <= '0;
                dir_reg[k]    <= '0;
            end
            eps_reg <= lti_pkg::EPS_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                lti_pkg::REG_ORIGIN_X: origin_reg[0] <= pwdata[W-1:0];
                lti_pkg::REG_ORIGIN_Y: origin_reg[1] <= pwdata[W-1:0];
                lti_pkg::REG_ORIGIN_Z: origin_reg[2] <= pwdata[W-1:0];
                lti_pkg::REG_DIR_X:    dir_reg[0]    <= pwdata[W-1:0];
                lti_pkg::REG_DIR_Y:    dir_reg[1]    <= pwdata[W-1:0];
                lti_pkg::REG_DIR_Z:    dir_reg[2]    <= pwdata[W-1:0];
                lti_pkg::REG_DET_EPS:  eps_reg       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lti_pkg::REG_ORIGIN_X: prdata = 32'(origin_reg[0]);
            lti_pkg::REG_ORIGIN_Y: prdata = 32'(origin_reg[1]);
            lti_pkg::REG_ORIGIN_Z: prdata = 32'(origin_reg[2]);
            lti_pkg::REG_DIR_X:    prdata = 32'(dir_reg[0]);
            lti_pkg::REG_DIR_Y:    prdata = 32'(dir_reg[1]);
            lti_pkg::REG_DIR_Z:    prdata = 32'(dir_reg[2]);
            lti_pkg::REG_DET_EPS:  prdata = eps_reg;
            default:               prdata = '0;
        endcase
    end

    lti_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin    (origin_reg),
        .dir       (dir_reg),
        .eps       (eps_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[9*W-1:0]),
        .out_valid (f_valid),
        .out_ready (!q_full),
        .out_flags (f_flags),
        .out_det   (f_det),
        .out_mag   (f_mag),
        .out_u     (f_u),
        .out_v     (f_v)
    );

    lti_fifo #(.EW(EW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .din   ({f_flags, f_det, f_mag, f_u, f_v}),
        .full  (q_full),
        .pop   (b_ready),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign {b_flags, b_det, b_mag, b_u, b_v} = q_dout;

    lti_back #(.DW(PW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_ready (b_ready),
        .in_flags (b_flags),
        .in_det   (b_det),
        .in_mag   (b_mag),
        .in_u     (b_u),
        .in_v     (b_v),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/core/lti_checker.sv
// ----------------------------------------------------------------------------
// lti_checker
// port-level checks on the result stream of the intersection engine
// ----------------------------------------------------------------------------
module lti_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lti_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // miss carries the fixed miss encoding
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == lti_pkg::MISS_PARAM
                                 && m_tdata[65:32] == 34'd0)
        else $error("miss result not in miss encoding");

    // hit weights lie inside the unit range
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[48:32] <= 17'h10000
                                && m_tdata[65:49] <= 17'h10000)
        else $error("weight out of range");

    // fill bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:66] == 6'd0)
        else $error("nonzero fill bits");

endmodule

bind line_triangle_intersect lti_checker u_lti_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_triangle_intersect testbench
// streams triangles against configured lines and checks every result against
// an exact fixed-point model of the two-sided crossing test
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW     = 24;
    localparam int IN_W   = ((9 * CW + 7) / 8) * 8;
    localparam int LAT    = 60;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      param;
        logic [16:0]      wu;
        logic [16:0]      wv;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [lti_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lti_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;

    coord_t line_org [3];
    coord_t line_dir [3];
    logic [31:0] eps_min;

    crossing_t pending_crossings [$];
    int mismatches = 0;
    bit stim_done = 1'b0;
    bit quiet_phase = 1'b0;

    always #1 clk = ~clk;

    line_triangle_intersect #(.COORD_WIDTH(CW)) dut (.*);

    // exact crossing prediction
    function automatic logic [127:0] quot16(logic [127:0] num, logic [127:0] den);
        return (num << 16) / den;
    endfunction

    function automatic crossing_t predict_crossing(coord_t vtx [9]);
        logic signed [127:0] o [3], d [3], a [3], e1 [3], e2 [3], tv [3], p [3], q [3];
        logic signed [127:0] det, u, v, t;
        logic [127:0] mag, quo;
        crossing_t r;
        r = '{1'b0, lti_pkg::MISS_PARAM, 17'd0, 17'd0};
        for (int k = 0; k < 3; k++)
        begin
            o[k] = line_org[k];
            d[k] = line_dir[k];
            a[k] = vtx[k];
            e1[k] = 128'(signed'(vtx[3+k])) - a[k];
            e2[k] = 128'(signed'(vtx[6+k])) - a[k];
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        for (int k = 0; k < 3; k++)
            tv[k] = (det > 0) ? o[k] - a[k] : a[k] - o[k];
        if (det <= 0)
            det = -det;
        if (det == 0 || det < $signed({96'd0, eps_min}))
            return r;
        u = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
        if (u < 0 || u > det)
            return r;
        q[0] = tv[1]*e1[2] - tv[2]*e1[1];
        q[1] = tv[2]*e1[0] - tv[0]*e1[2];
        q[2] = tv[0]*e1[1] - tv[1]*e1[0];
        v = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        if (v < 0 || u + v > det)
            return r;
        t = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        mag = (t < 0) ? -t : t;
        quo = quot16(mag, det);
        if (t < 0)
            r.param = (quo > 128'h8000_0000) ? lti_pkg::NEG_LIMIT : 32'(-quo);
        else
            r.param = (quo > 128'h7FFF_FFFF) ? lti_pkg::MISS_PARAM : quo[31:0];
        r.hit = 1'b1;
        r.wu = 17'(quot16(u, det));
        r.wv = 17'(quot16(v, det));
        return r;
    endfunction

    task automatic write_reg(lti_pkg::reg_index_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= lti_pkg::ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == lti_pkg::REG_DET_EPS)
            eps_min = val;
        else if (idx < lti_pkg::REG_DIR_X)
            line_org[idx] = val[CW-1:0];
        else
            line_dir[idx - lti_pkg::REG_DIR_X] = val[CW-1:0];
    endtask

    task automatic set_line(coord_t ox, coord_t oy, coord_t oz,
                            coord_t dx, coord_t dy, coord_t dz, logic [31:0] e);
        s_tvalid <= 1'b0;
        wait (pending_crossings.size() == 0);
        repeat (LAT) @(posedge clk);
        write_reg(lti_pkg::REG_ORIGIN_X, 32'(ox));
        write_reg(lti_pkg::REG_ORIGIN_Y, 32'(oy));
        write_reg(lti_pkg::REG_ORIGIN_Z, 32'(oz));
        write_reg(lti_pkg::REG_DIR_X, 32'(dx));
        write_reg(lti_pkg::REG_DIR_Y, 32'(dy));
        write_reg(lti_pkg::REG_DIR_Z, 32'(dz));
        write_reg(lti_pkg::REG_DET_EPS, e);
    endtask

    task automatic send_triangle(coord_t vtx [9]);
        int gap;
        logic [IN_W-1:0] packed_vtx;
        gap = quiet_phase ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0);
        packed_vtx = '0;
        for (int k = 0; k < 9; k++)
            packed_vtx[k*CW +: CW] = vtx[k];
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= packed_vtx;
        do @(posedge clk); while (!s_tready);
        pending_crossings.push_back(predict_crossing(vtx));
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 32768)) - 16384);
            2: return ($urandom_range(0, 1) != 0) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
            default: return coord_t'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // triangle built around a point on the line
    task automatic send_aimed(int mode);
        coord_t vtx [9];
        int s;
        s = $urandom_range(0, 4096);
        for (int k = 0; k < 9; k++)
        begin
            vtx[k] = coord_t'(line_org[k%3] + ((longint'(line_dir[k%3]) * s) >>> 12)
                     + rand_coord(mode));
        end
        send_triangle(vtx);
    endtask

    task automatic send_random(int mode);
        coord_t vtx [9];
        for (int k = 0; k < 9; k++)
            vtx[k] = rand_coord(mode);
        send_triangle(vtx);
    endtask

    task automatic test_directed();
        coord_t vtx [9];
        set_line(0, 0, -24'sd4096, 0, 0, 24'sd4096, 32'd1);
        // plain hit, then the same triangle wound the other way
        vtx = '{-24'sd4096, -24'sd4096, 24'sd8192, 24'sd4096, -24'sd4096, 24'sd8192,
                -24'sd4096, 24'sd4096, 24'sd8192};
        send_triangle(vtx);
        vtx = '{-24'sd4096, -24'sd4096, 24'sd8192, -24'sd4096, 24'sd4096, 24'sd8192,
                24'sd4096, -24'sd4096, 24'sd8192};
        send_triangle(vtx);
        // triangle behind the origin gives a negative parameter
        vtx = '{-24'sd4096, -24'sd4096, -24'sd8192, 24'sd4096, -24'sd4096, -24'sd8192,
                -24'sd4096, 24'sd4096, -24'sd8192};
        send_triangle(vtx);
        // line crossing a tilted plane at a corner
        vtx = '{0, 0, 0, 24'sd4096, 0, 24'sd4096, 0, 24'sd4096, 24'sd4096};
        send_triangle(vtx);
        // degenerate triangle
        vtx = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_triangle(vtx);
        // outside the triangle
        vtx = '{24'sd100, 24'sd100, 0, 24'sd8192, 24'sd100, 0, 24'sd100, 24'sd8192, 0};
        send_triangle(vtx);
        // hit on a vertex and on an edge
        vtx = '{0, 0, 0, 24'sd4096, 0, 0, 0, 24'sd4096, 0};
        send_triangle(vtx);
        vtx = '{-24'sd4096, 0, 0, 24'sd4096, 0, 0, 0, 24'sd4096, 0};
        send_triangle(vtx);
        // extreme corners
        vtx = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                24'h800000, 24'h7FFFFF, 24'h7FFFFF};
        send_triangle(vtx);
        vtx = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                24'h7FFFFF, 24'h800000, 24'h800000};
        send_triangle(vtx);
        // tiny direction, far plane: parameter saturates
        set_line(0, 0, 0, 0, 0, 24'sd1, 32'd0);
        vtx = '{-24'h7FFFFF, -24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, -24'h7FFFFF, 24'h7FFFFF,
                -24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
        send_triangle(vtx);
        vtx = '{-24'h7FFFFF, -24'h7FFFFF, 24'h800000, 24'h7FFFFF, -24'h7FFFFF, 24'h800000,
                -24'h7FFFFF, 24'h7FFFFF, 24'h800000};
        send_triangle(vtx);
        // zero determinant with zero threshold
        vtx = '{0, 0, 0, 24'sd1, 0, 0, 24'sd2, 0, 0};
        send_triangle(vtx);
        // threshold at its maximum kills small determinants
        set_line(0, 0, -24'sd4096, 0, 0, 24'sd4096, 32'hFFFF_FFFF);
        vtx = '{-24'sd4096, -24'sd4096, 24'sd8192, 24'sd4096, -24'sd4096, 24'sd8192,
                -24'sd4096, 24'sd4096, 24'sd8192};
        send_triangle(vtx);
        vtx = '{-24'sd409600, -24'sd409600, 0, 24'sd409600, -24'sd409600, 0,
                -24'sd409600, 24'sd409600, 0};
        send_triangle(vtx);
    endtask

    task automatic test_random_lines();
        for (int phase = 0; phase < 12; phase++)
        begin
            int m;
            m = phase % 4;
            quiet_phase = (phase % 5 == 4);
            set_line(rand_coord(m), rand_coord(m), rand_coord(m),
                     (m == 2) ? rand_coord(2) : rand_coord(1),
                     rand_coord(1), rand_coord(m == 0 ? 0 : 3),
                     (phase % 3 == 0) ? $urandom : $urandom_range(0, 4));
            for (int i = 0; i < 120; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_aimed($urandom_range(0, 3));
                else
                    send_random($urandom_range(0, 3));
            end
        end
        quiet_phase = 1'b0;
    endtask

    // result draining with random stalls
    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                crossing_t got, want;
                got = '{m_tuser, m_tdata[31:0], m_tdata[48:32], m_tdata[65:49]};
                if (pending_crossings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %p", got);
                end
                else
                begin
                    want = pending_crossings.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
                stall = quiet_phase ? 0 :
                        (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        line_org = '{0, 0, 0};
        line_dir = '{0, 0, 0};
        eps_min = 32'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_lines();
        s_tvalid <= 1'b0;
        wait (pending_crossings.size() == 0);
        repeat (LAT) @(posedge clk);
        if (mismatches == 0 && pending_crossings.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lti_pkg.sv
rtl/core/lti_mul.sv
rtl/core/lti_div.sv
rtl/core/lti_fifo.sv
rtl/core/lti_front.sv
rtl/core/lti_back.sv
rtl/core/line_triangle_intersect.sv
rtl/core/lti_checker.sv
tb/testbench.sv
